>>> rtl/pgh_pkg.sv
// Shared types and constants for the gossip handshake block.
package pgh_pkg;

  localparam int MaxNeighbors = 16;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_REQ  = 2'd1,
    ST_ACK  = 2'd2,
    ST_BAD  = 2'd3
  } hs_state_t;

  typedef enum logic [2:0] {
    CFG_MY_ID     = 3'd0,
    CFG_IDLE_RNDS = 3'd1,
    CFG_REQ_RNDS  = 3'd2,
    CFG_ACK_RNDS  = 3'd3,
    CFG_DICE_MOD  = 3'd4,
    CFG_STAY_THR  = 3'd5,
    CFG_NONCE_MOD = 3'd6,
    CFG_NONE      = 3'd7
  } cfg_idx_t;

  // Sequencer steps for one word.
  typedef enum logic [2:0] {
    SQ_IDLE  = 3'd0,
    SQ_MOD   = 3'd1,
    SQ_READ  = 3'd2,
    SQ_WAIT  = 3'd3,
    SQ_APPLY = 3'd4,
    SQ_OUT   = 3'd5
  } seq_t;

endpackage

>>> rtl/pairwise_gossip_handshake_fsm_core.sv
// Top level of the pairwise gossip handshake state machine.
//
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_stall   | req_type, nbr_id, nbr_req_id, nbr_ack_id, nbr_nonce,
//         |     |                       | random_pick, random_dice
// out     | out | out_valid / out_stall | round_state .. do_consensus
// cfg     | in  | cfg_we                | cfg_index, cfg_data
//
// A neighbor record is accepted, then written to the list memories; the input
// stalls until that write is done. A round end runs from accept to the next
// accept through 16 steps of three bit-serial remainders run side by side
// (pick, dice, nonce), a memory read, a wait for read data, an apply step and
// an output step. The wait step holds while an earlier word is still stalled
// in the output register, and so does the output step. Reset is synchronous
// and clears control state; the lists need no clearing. The next word is
// accepted while a result word waits under out_stall.
module pairwise_gossip_handshake_fsm_core #(
  parameter int MAX_NEIGHBORS = pgh_pkg::MaxNeighbors
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  nbr_id,
  input  logic [7:0]  nbr_req_id,
  input  logic [7:0]  nbr_ack_id,
  input  logic [7:0]  nbr_nonce,
  input  logic [15:0] random_pick,
  input  logic [15:0] random_dice,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  round_state,
  output logic [1:0]  new_state,
  output logic [7:0]  bcast_req_id,
  output logic [7:0]  bcast_ack_id,
  output logic [7:0]  bcast_nonce,
  output logic        capture_valid,
  output logic [7:0]  capture_id,
  output logic        do_consensus,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CW = $clog2(MAX_NEIGHBORS + 1);

  // configuration
  logic [7:0]  my_id, idle_rounds, request_rounds, ack_rounds, nonce_modulus;
  logic [15:0] dice_modulus, stay_idle_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_id <= 8'd1; idle_rounds <= 8'd10; request_rounds <= 8'd5;
      ack_rounds <= 8'd5; dice_modulus <= 16'd100;
      stay_idle_threshold <= 16'd50; nonce_modulus <= 8'd255;
    end else if (cfg_we) begin
      case (pgh_pkg::cfg_idx_t'(cfg_index))
        pgh_pkg::CFG_MY_ID:     my_id <= cfg_data[7:0];
        pgh_pkg::CFG_IDLE_RNDS: idle_rounds <= cfg_data[7:0];
        pgh_pkg::CFG_REQ_RNDS:  request_rounds <= cfg_data[7:0];
        pgh_pkg::CFG_ACK_RNDS:  ack_rounds <= cfg_data[7:0];
        pgh_pkg::CFG_DICE_MOD:  dice_modulus <= cfg_data;
        pgh_pkg::CFG_STAY_THR:  stay_idle_threshold <= cfg_data;
        pgh_pkg::CFG_NONCE_MOD: nonce_modulus <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // list memories: neighbor ids, and requester id plus nonce
  logic [7:0]  nbr_mem [MAX_NEIGHBORS];
  logic [15:0] rq_mem  [MAX_NEIGHBORS];
  logic        nbr_wr, rq_wr;
  logic [AW-1:0] nbr_waddr, rq_waddr, rd_addr;
  logic [7:0]  nbr_wdata, nbr_rdata;
  logic [15:0] rq_wdata, rq_rdata;

  always_ff @(posedge clk) begin
    if (nbr_wr) nbr_mem[nbr_waddr] <= nbr_wdata;
    nbr_rdata <= nbr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rq_wr) rq_mem[rq_waddr] <= rq_wdata;
    rq_rdata <= rq_mem[rd_addr];
  end

  // handshake state
  pgh_pkg::hs_state_t fsm_state;
  logic [7:0] rounds_in_state, own_req_id, own_ack_id, own_nonce;
  logic [7:0] last_served_id, last_served_nonce;
  logic       last_served_valid, request_done, partner_acked;
  logic [CW-1:0] neighbor_count, requester_count;

  // sequencer
  pgh_pkg::seq_t seq, seq_next;
  logic        rec_pend;
  logic [7:0]  h_id, h_req, h_ack, h_non;
  logic [15:0] h_pick, h_dice;
  logic [4:0]  bit_cnt;
  logic [16:0] rem_p, rem_d;   // serial remainders
  logic [9:0]  rem_n;          // serial nonce remainder
  logic        roll_stay;

  logic accept_in;
  assign in_stall  = (seq != pgh_pkg::SQ_IDLE) || rec_pend;
  assign accept_in = in_valid && !in_stall;

  // output register
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // next step of the sequencer
  always_comb begin
    seq_next = seq;
    case (seq)
      pgh_pkg::SQ_IDLE:  if (accept_in && req_type) seq_next = pgh_pkg::SQ_MOD;
      pgh_pkg::SQ_MOD:   if (bit_cnt == 5'd15) seq_next = pgh_pkg::SQ_READ;
      pgh_pkg::SQ_READ:  seq_next = pgh_pkg::SQ_WAIT;
      pgh_pkg::SQ_WAIT:  if (out_free) seq_next = pgh_pkg::SQ_APPLY;
      pgh_pkg::SQ_APPLY: seq_next = pgh_pkg::SQ_OUT;
      pgh_pkg::SQ_OUT:   if (out_free) seq_next = pgh_pkg::SQ_IDLE;
      default:           seq_next = pgh_pkg::SQ_IDLE;
    endcase
  end

  logic [7:0] rounds_in_state_inc;
  assign rounds_in_state_inc = (rounds_in_state == 8'd255) ? 8'd255 : rounds_in_state + 8'd1;

  logic [8:0] nonce_sum;
  assign nonce_sum = {1'b0, own_nonce} + 9'd1;

  // one restoring step of each remainder
  logic [15:0] div_p, div_d, n_src;
  logic [16:0] tp, td;
  logic [9:0]  tn;
  logic        fresh;
  always_comb begin
    div_p = {{(16-CW){1'b0}}, requester_count};
    div_d = dice_modulus;
    if (!(fsm_state == pgh_pkg::ST_IDLE && rounds_in_state_inc <= idle_rounds))
      div_p = {{(16-CW){1'b0}}, neighbor_count};
    n_src = {7'd0, nonce_sum};
    tp = {rem_p[15:0], h_pick[4'd15 - bit_cnt[3:0]]};
    td = {rem_d[15:0], h_dice[4'd15 - bit_cnt[3:0]]};
    tn = {rem_n[8:0], n_src[4'd15 - bit_cnt[3:0]]};
    if (tp >= {1'b0, div_p}) tp = tp - {1'b0, div_p};
    if (td >= {1'b0, div_d}) td = td - {1'b0, div_d};
    if (tn >= {2'b0, nonce_modulus}) tn = tn - {2'b0, nonce_modulus};
    fresh = (h_req == my_id) &&
            !(last_served_valid && h_id == last_served_id && h_non == last_served_nonce);
  end

  // list writes and read address
  always_comb begin
    nbr_wr    = rec_pend && neighbor_count < CW'(MAX_NEIGHBORS);
    nbr_waddr = neighbor_count[AW-1:0];
    nbr_wdata = h_id;
    rq_wr     = rec_pend && fresh && requester_count < CW'(MAX_NEIGHBORS);
    rq_waddr  = requester_count[AW-1:0];
    rq_wdata  = {h_id, h_non};
    rd_addr   = rem_p[AW-1:0];
  end

  logic [7:0] nonce_inc;
  always_comb begin
    if (nonce_modulus == 8'd0) nonce_inc = nonce_sum[7:0];
    else nonce_inc = rem_n[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= pgh_pkg::SQ_IDLE;
      rec_pend <= 1'b0;
      fsm_state <= pgh_pkg::ST_IDLE;
      rounds_in_state <= '0; own_req_id <= '0; own_ack_id <= '0; own_nonce <= '0;
      last_served_id <= '0; last_served_nonce <= '0; last_served_valid <= 1'b0;
      request_done <= 1'b0; partner_acked <= 1'b0;
      neighbor_count <= '0; requester_count <= '0;
      out_valid <= 1'b0;
      bit_cnt <= '0;
    end else begin
      seq <= seq_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      // latch input word
      if (accept_in) begin
        h_id <= nbr_id; h_req <= nbr_req_id; h_ack <= nbr_ack_id; h_non <= nbr_nonce;
        h_pick <= random_pick; h_dice <= random_dice;
        rec_pend <= !req_type && nbr_id != 8'd0;
        bit_cnt <= '0; rem_p <= '0; rem_d <= '0; rem_n <= '0;
      end
      // store a neighbor record
      if (rec_pend) begin
        rec_pend <= 1'b0;
        if (nbr_wr) neighbor_count <= neighbor_count + CW'(1);
        if (rq_wr) requester_count <= requester_count + CW'(1);
        if (h_id == own_req_id && h_ack == my_id) partner_acked <= 1'b1;
      end
      // serial remainders
      if (seq == pgh_pkg::SQ_MOD) begin
        rem_p <= tp; rem_d <= td; rem_n <= tn; bit_cnt <= bit_cnt + 5'd1;
      end
      if (seq == pgh_pkg::SQ_READ)
        roll_stay <= ((dice_modulus == 16'd0) ? h_dice : rem_d[15:0]) < stay_idle_threshold;
      // apply the round
      if (seq == pgh_pkg::SQ_APPLY) begin
        round_state <= fsm_state;
        capture_valid <= 1'b0; capture_id <= '0; do_consensus <= 1'b0;
        rounds_in_state <= rounds_in_state_inc;
        new_state <= fsm_state;
        bcast_req_id <= own_req_id; bcast_ack_id <= own_ack_id; bcast_nonce <= own_nonce;
        case (fsm_state)
          pgh_pkg::ST_IDLE: begin
            if (rounds_in_state_inc <= idle_rounds) begin
              if (requester_count != '0) begin
                last_served_id <= rq_rdata[15:8];
                last_served_nonce <= rq_rdata[7:0];
                last_served_valid <= 1'b1;
                fsm_state <= pgh_pkg::ST_ACK; new_state <= pgh_pkg::ST_ACK;
                rounds_in_state <= '0;
                own_ack_id <= rq_rdata[15:8]; bcast_ack_id <= rq_rdata[15:8];
                capture_valid <= 1'b1; capture_id <= rq_rdata[15:8];
              end
            end else begin
              rounds_in_state <= '0;
              if (!roll_stay) begin
                fsm_state <= pgh_pkg::ST_REQ; new_state <= pgh_pkg::ST_REQ;
                own_nonce <= nonce_inc; bcast_nonce <= nonce_inc;
                own_req_id <= (neighbor_count != '0) ? nbr_rdata : 8'd0;
                bcast_req_id <= (neighbor_count != '0) ? nbr_rdata : 8'd0;
                request_done <= 1'b0;
              end
            end
          end
          pgh_pkg::ST_REQ: begin
            if (rounds_in_state_inc <= request_rounds) begin
              if (!request_done && partner_acked) begin
                capture_valid <= 1'b1; capture_id <= own_req_id; request_done <= 1'b1;
              end
            end else begin
              do_consensus <= request_done;
              fsm_state <= pgh_pkg::ST_IDLE; new_state <= pgh_pkg::ST_IDLE;
              rounds_in_state <= '0;
              own_req_id <= '0; own_ack_id <= '0; bcast_req_id <= '0; bcast_ack_id <= '0;
            end
          end
          pgh_pkg::ST_ACK: begin
            if (rounds_in_state_inc > ack_rounds) begin
              do_consensus <= 1'b1;
              fsm_state <= pgh_pkg::ST_IDLE; new_state <= pgh_pkg::ST_IDLE;
              rounds_in_state <= '0;
              own_req_id <= '0; own_ack_id <= '0; bcast_req_id <= '0; bcast_ack_id <= '0;
            end
          end
          default: begin
            fsm_state <= pgh_pkg::ST_IDLE; new_state <= pgh_pkg::ST_IDLE;
            rounds_in_state <= '0;
            own_req_id <= '0; own_ack_id <= '0; bcast_req_id <= '0; bcast_ack_id <= '0;
          end
        endcase
        neighbor_count <= '0; requester_count <= '0; partner_acked <= 1'b0;
      end
      // hand word to output register
      if (seq == pgh_pkg::SQ_OUT && out_free) out_valid <= 1'b1;
    end
  end

endmodule

>>> rtl/pgh_checker.sv
// Port-level checker for the gossip handshake block, with its bind.
module pgh_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] new_state,
  input logic [1:0] round_state,
  input logic       capture_valid,
  input logic [7:0] capture_id,
  input logic       do_consensus,
  input logic [7:0] bcast_req_id,
  input logic [7:0] bcast_ack_id
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_state))
    else $error("result word dropped under stall");

  a_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> new_state != pgh_pkg::ST_BAD)
    else $error("new state out of range");

  a_idle_ids: assert property (@(posedge clk) disable iff (rst)
    out_valid && do_consensus |-> new_state == pgh_pkg::ST_IDLE && bcast_req_id == 8'd0
      && bcast_ack_id == 8'd0)
    else $error("consensus without return to idle");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && capture_valid && round_state == pgh_pkg::ST_IDLE
      |-> capture_id == bcast_ack_id)
    else $error("capture id differs from ack id");

endmodule

bind pairwise_gossip_handshake_fsm_core pgh_checker u_pgh_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .new_state(new_state), .round_state(round_state),
  .capture_valid(capture_valid), .capture_id(capture_id),
  .do_consensus(do_consensus), .bcast_req_id(bcast_req_id),
  .bcast_ack_id(bcast_ack_id)
);

>>> tb/pairwise_gossip_handshake_fsm_core_tb.sv
// Self-checking testbench for the gossip handshake core: directed rounds, then random rounds.
`timescale 1ns / 1ps
module pairwise_gossip_handshake_fsm_core_tb;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  nbr_id;
    logic [7:0]  nbr_req_id;
    logic [7:0]  nbr_ack_id;
    logic [7:0]  nbr_nonce;
    logic [15:0] random_pick;
    logic [15:0] random_dice;
  } word_in_t;

  typedef struct packed {
    logic [1:0] round_state;
    logic [1:0] new_state;
    logic [7:0] bcast_req_id;
    logic [7:0] bcast_ack_id;
    logic [7:0] bcast_nonce;
    logic       capture_valid;
    logic [7:0] capture_id;
    logic       do_consensus;
  } round_out_t;

  // Directed table row: a word plus an optional typed-in result.
  typedef struct {
    word_in_t   w;
    logic       has_exp;
    round_out_t exp;
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  word_in_t drv;
  round_out_t got;
  logic cfg_we;
  pgh_pkg::cfg_idx_t cfg_index;
  logic [15:0] cfg_data;

  pairwise_gossip_handshake_fsm_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(drv.req_type), .nbr_id(drv.nbr_id), .nbr_req_id(drv.nbr_req_id),
    .nbr_ack_id(drv.nbr_ack_id), .nbr_nonce(drv.nbr_nonce),
    .random_pick(drv.random_pick), .random_dice(drv.random_dice),
    .out_valid(out_valid), .out_stall(out_stall),
    .round_state(got.round_state), .new_state(got.new_state),
    .bcast_req_id(got.bcast_req_id), .bcast_ack_id(got.bcast_ack_id),
    .bcast_nonce(got.bcast_nonce), .capture_valid(got.capture_valid),
    .capture_id(got.capture_id), .do_consensus(got.do_consensus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the configuration and node state
  logic [7:0]  p_my_id, p_idle_rnds, p_req_rnds, p_ack_rnds, p_nonce_mod;
  logic [15:0] p_dice_mod, p_stay_thr;
  pgh_pkg::hs_state_t p_state;
  logic [7:0]  p_rounds, p_req_id, p_ack_id, p_nonce, p_srv_id, p_srv_nonce;
  logic        p_srv_valid, p_req_done, p_acked;
  logic [7:0]  p_nbrs [pgh_pkg::MaxNeighbors];
  logic [7:0]  p_rq_ids [pgh_pkg::MaxNeighbors];
  logic [7:0]  p_rq_nonces [pgh_pkg::MaxNeighbors];
  int          p_nbr_cnt, p_rq_cnt;

  round_out_t  round_q[$];
  int          errors = 0, rounds_seen = 0, words_sent = 0, cycles = 0;
  int          max_idle_gap = 17;

  function automatic void node_reset();
    p_my_id = 1; p_idle_rnds = 10; p_req_rnds = 5; p_ack_rnds = 5;
    p_dice_mod = 100; p_stay_thr = 50; p_nonce_mod = 255;
    p_state = pgh_pkg::ST_IDLE; p_rounds = 0; p_req_id = 0; p_ack_id = 0; p_nonce = 0;
    p_srv_id = 0; p_srv_nonce = 0; p_srv_valid = 0; p_req_done = 0; p_acked = 0;
    p_nbr_cnt = 0; p_rq_cnt = 0;
  endfunction

  function automatic void node_config(pgh_pkg::cfg_idx_t idx, logic [15:0] v);
    case (idx)
      pgh_pkg::CFG_MY_ID:     p_my_id = v[7:0];
      pgh_pkg::CFG_IDLE_RNDS: p_idle_rnds = v[7:0];
      pgh_pkg::CFG_REQ_RNDS:  p_req_rnds = v[7:0];
      pgh_pkg::CFG_ACK_RNDS:  p_ack_rnds = v[7:0];
      pgh_pkg::CFG_DICE_MOD:  p_dice_mod = v;
      pgh_pkg::CFG_STAY_THR:  p_stay_thr = v;
      pgh_pkg::CFG_NONCE_MOD: p_nonce_mod = v[7:0];
      default: ;
    endcase
  endfunction

  // Advance the node by one word; return 1 with the round result on round end.
  function automatic bit node_step(word_in_t w, output round_out_t r);
    int k, roll;
    r = '0;
    if (!w.req_type) begin
      if (w.nbr_id == 0) return 0;
      if (p_nbr_cnt < pgh_pkg::MaxNeighbors) begin
        p_nbrs[p_nbr_cnt] = w.nbr_id;
        p_nbr_cnt++;
      end
      if (w.nbr_req_id == p_my_id &&
          !(p_srv_valid && w.nbr_id == p_srv_id && w.nbr_nonce == p_srv_nonce) &&
          p_rq_cnt < pgh_pkg::MaxNeighbors) begin
        p_rq_ids[p_rq_cnt] = w.nbr_id;
        p_rq_nonces[p_rq_cnt] = w.nbr_nonce;
        p_rq_cnt++;
      end
      if (w.nbr_id == p_req_id && w.nbr_ack_id == p_my_id) p_acked = 1;
      return 0;
    end
    r.round_state = p_state;
    if (p_rounds != 8'hFF) p_rounds++;
    case (p_state)
      pgh_pkg::ST_IDLE: begin
        if (p_rounds <= p_idle_rnds) begin
          if (p_rq_cnt != 0) begin
            k = int'(w.random_pick) % p_rq_cnt;
            p_srv_id = p_rq_ids[k]; p_srv_nonce = p_rq_nonces[k]; p_srv_valid = 1;
            p_state = pgh_pkg::ST_ACK; p_rounds = 0; p_ack_id = p_srv_id;
            r.capture_valid = 1; r.capture_id = p_srv_id;
          end
        end else begin
          roll = p_dice_mod != 0 ? int'(w.random_dice) % int'(p_dice_mod)
                                 : int'(w.random_dice);
          p_rounds = 0;
          if (roll >= int'(p_stay_thr)) begin
            p_state = pgh_pkg::ST_REQ;
            p_nonce = p_nonce_mod != 0 ? 8'((int'(p_nonce) + 1) % int'(p_nonce_mod))
                                       : p_nonce + 8'd1;
            p_req_id = p_nbr_cnt != 0 ? p_nbrs[int'(w.random_pick) % p_nbr_cnt] : 8'd0;
            p_req_done = 0;
          end
        end
      end
      pgh_pkg::ST_REQ: begin
        if (p_rounds <= p_req_rnds) begin
          if (!p_req_done && p_acked) begin
            r.capture_valid = 1; r.capture_id = p_req_id; p_req_done = 1;
          end
        end else begin
          r.do_consensus = p_req_done;
          p_state = pgh_pkg::ST_IDLE; p_rounds = 0; p_req_id = 0; p_ack_id = 0;
        end
      end
      pgh_pkg::ST_ACK: begin
        if (p_rounds > p_ack_rnds) begin
          r.do_consensus = 1;
          p_state = pgh_pkg::ST_IDLE; p_rounds = 0; p_req_id = 0; p_ack_id = 0;
        end
      end
      default: begin
        p_state = pgh_pkg::ST_IDLE; p_rounds = 0; p_req_id = 0; p_ack_id = 0;
      end
    endcase
    p_nbr_cnt = 0; p_rq_cnt = 0; p_acked = 0;
    r.new_state = p_state; r.bcast_req_id = p_req_id;
    r.bcast_ack_id = p_ack_id; r.bcast_nonce = p_nonce;
    return 1;
  endfunction

  // Clock and cycle limit
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Compare every accepted round result with the oldest expectation
  always @(posedge clk) begin
    round_out_t e;
    if (!rst && out_valid && !out_stall) begin
      rounds_seen++;
      if (round_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected round word %p", $time, got);
      end else begin
        e = round_q.pop_front();
        if (got !== e) begin
          errors++;
          $display("%0t: round mismatch expected %p actual %p", $time, e, got);
        end
      end
    end
  end

  // Receiver stall: random hold per word, with quiet stretches
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (out_valid && !out_stall) begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_idle_gap);
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(negedge clk);
          out_stall <= 0;
        end
      end else if (!out_valid) begin
        out_stall <= ($urandom_range(0, 7) == 0);
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic word_in_t nbr_word(logic [7:0] id, logic [7:0] rq, logic [7:0] ak,
                                        logic [7:0] nn);
    word_in_t w;
    w = '{1'b0, id, rq, ak, nn, 16'($urandom), 16'($urandom)};
    return w;
  endfunction

  function automatic word_in_t end_word(logic [15:0] pick, logic [15:0] dice);
    word_in_t w;
    w = '{1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), pick, dice};
    return w;
  endfunction

  // Drive one word, with a random gap before it unless quiet; predict on acceptance
  task automatic send_word(word_in_t w, bit quiet);
    round_out_t r;
    int gap;
    gap = quiet ? 0 : $urandom_range(0, max_idle_gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    drv <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (node_step(w, r)) round_q.push_back(r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (round_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(pgh_pkg::cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    node_config(idx, v);
  endtask

  task automatic write_all(logic [7:0] me, logic [7:0] ir, logic [7:0] rr, logic [7:0] ar,
                           logic [15:0] dm, logic [15:0] th, logic [7:0] nm);
    write_reg(pgh_pkg::CFG_MY_ID, me); write_reg(pgh_pkg::CFG_IDLE_RNDS, ir);
    write_reg(pgh_pkg::CFG_REQ_RNDS, rr); write_reg(pgh_pkg::CFG_ACK_RNDS, ar);
    write_reg(pgh_pkg::CFG_DICE_MOD, dm); write_reg(pgh_pkg::CFG_STAY_THR, th);
    write_reg(pgh_pkg::CFG_NONCE_MOD, nm);
    cfg_we <= 0;
  endtask

  // One round with random records, mostly aimed at this node and its partner
  task automatic random_round(int burst);
    int n;
    logic [7:0] id, rq, ak;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(0, 3) == 0 && p_req_id != 0) ? p_req_id : 8'($urandom_range(0, 12));
      rq = ($urandom_range(0, 1) == 0) ? p_my_id : 8'($urandom);
      ak = ($urandom_range(0, 1) == 0) ? p_my_id : 8'($urandom);
      if ($urandom_range(0, 3) == 0 && p_srv_valid) begin
        id = p_srv_id;
        send_word(nbr_word(id, p_my_id, ak, p_srv_nonce), burst != 0);
      end else begin
        send_word(nbr_word(id, rq, ak, 8'($urandom_range(0, 3) == 0 ? $urandom : i)),
                  burst != 0);
      end
    end
    send_word(end_word(16'($urandom), 16'($urandom)), burst != 0);
  endtask

  // Stimulus
  initial begin
    dir_row_t dir_rows[$];
    dir_row_t row;
    round_out_t r0;
    int bursts;
    rst = 1; in_valid = 0; drv = '0; cfg_we = 0; cfg_index = pgh_pkg::CFG_MY_ID; cfg_data = 0;
    node_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed table: known results right after reset
    r0 = '0;
    row = '{end_word(16'hFFFF, 16'hFFFF), 1'b1, r0};
    dir_rows.push_back(row);
    row = '{nbr_word(8'd0, 8'd1, 8'd1, 8'd0), 1'b0, r0};       // bad neighbor
    dir_rows.push_back(row);
    row = '{nbr_word(8'd255, 8'd1, 8'd0, 8'd255), 1'b0, r0};   // requester at max id
    dir_rows.push_back(row);
    r0.new_state = pgh_pkg::ST_ACK; r0.bcast_ack_id = 8'd255;
    r0.capture_valid = 1; r0.capture_id = 8'd255;
    row = '{end_word(16'h0000, 16'h0000), 1'b1, r0};
    dir_rows.push_back(row);
    row = '{nbr_word(8'd255, 8'd1, 8'd0, 8'd255), 1'b0, r0};   // stale repeat
    dir_rows.push_back(row);
    for (int i = 0; i < 6; i++) begin
      row = '{end_word(16'($urandom), 16'($urandom)), 1'b0, r0};
      dir_rows.push_back(row);
    end
    for (int i = 0; i < 18; i++) begin                         // list overflow
      row = '{nbr_word(8'(i + 1), 8'd1, 8'd1, 8'(i)), 1'b0, r0};
      dir_rows.push_back(row);
    end
    row = '{end_word(16'hFFFF, 16'h8000), 1'b0, r0};
    dir_rows.push_back(row);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        round_out_t pr;
        word_in_t w;
        w = dir_rows[i].w;
        // compare the typed value against the freshly queued prediction
        send_word(w, 0);
        pr = round_q[round_q.size() - 1];
        if (pr !== dir_rows[i].exp) begin
          errors++;
          $display("%0t: table row %0d expected %p actual %p", $time, i,
                   dir_rows[i].exp, pr);
        end
      end else begin
        send_word(dir_rows[i].w, 0);
      end
    end
    drain();

    // Random phases under several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(8'd7, 8'd0, 8'd0, 8'd0, 16'd1, 16'd0, 8'd2);
        1: write_all(8'd255, 8'd254, 8'd254, 8'd254, 16'hFFFF, 16'hFFFF, 8'd255);
        2: write_all(8'd3, 8'd1, 8'd3, 8'd2, 16'd0, 16'h8000, 8'd0);
        3: write_all(8'd1, 8'd2, 8'd4, 8'd1, 16'd100, 16'd30, 8'd5);
        4: write_all(8'($urandom_range(1, 255)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
                     16'($urandom_range(1, 65535)), 16'($urandom), 8'($urandom_range(2, 255)));
        default: write_all(8'd2, 8'd0, 8'd2, 8'd1, 16'd10, 16'd3, 8'd3);
      endcase
      bursts = 0;
      while (words_sent < 120 * (ph + 1) + 40) begin
        if (bursts == 0 && $urandom_range(0, 9) == 0) bursts = $urandom_range(3, 8);
        random_round(bursts);
        if (bursts > 0) bursts--;
      end
      drain();
    end

    $display("Covered %0d input words and %0d round results over 6 register settings.",
             words_sent, rounds_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
